FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the collision pipeline rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPLY(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: check failed");
`define CHK_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");
`else
`define CHK_IMPLY(name, pre, post)
`define CHK_NEXT(name, pre, post)
`endif
`endif

FILE: hw/rtl/ec3d_pkg.sv
// shared types and constants for the 3d elastic collision pipeline
`timescale 1ns / 1ps
package ec3d_pkg;

    localparam int WORD_W      = 32;
    localparam int MASS_W      = 31;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int QUO_W       = 33;
    localparam int NORM_STAGES = 6;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 33;
    localparam int EXCH_STAGES = 12;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_HIT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t [2:0] va;
        word_t [2:0] vb;
    } vel_pair_t;

    // sideband from the front end to the dividers
    typedef struct packed {
        status_t                 status;
        logic [2:0]              neg;
        vel_pair_t               vel;
        logic [2:0][WORD_W-1:0]  ar;
        logic [MASS_W-1:0]       ma;
        logic [MASS_W-1:0]       mb;
    } norm_side_t;

    // sideband from the dividers to the exchange stages
    typedef struct packed {
        status_t    status;
        logic [2:0] neg;
        vel_pair_t  vel;
        logic       szero;
    } exch_side_t;

endpackage

FILE: hw/rtl/ec3d_norm.sv
// front end: contact status, magnitudes, normalising shift and sum of squares
`timescale 1ns / 1ps
module ec3d_norm
    import ec3d_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [WORD_W-1:0]      separation,
    input  logic [MASS_W-1:0]             mass_a,
    input  logic [MASS_W-1:0]             mass_b,
    input  vel_pair_t                     vel,
    input  logic [2:0][WORD_W-1:0]        rel_pos,
    output logic                          out_valid,
    output logic [SQ_W-1:0]               sq,
    output norm_side_t                    side
);

    norm_side_t             side1_next;
    norm_side_t             side1_reg;
    norm_side_t             side2_reg;
    norm_side_t             side3_reg;
    norm_side_t             side4_next;
    norm_side_t             side4_reg;
    norm_side_t             side5_reg;
    norm_side_t             side6_reg;
    logic [WORD_W-1:0]      mx2_next;
    logic [WORD_W-1:0]      mx2_reg;
    logic [WORD_W-1:0]      mx01;
    logic [5:0]             lz;
    logic [4:0]             sh3_next;
    logic [4:0]             sh3_reg;
    logic [SQ_W-1:0]        sqp5_next [3];
    logic [SQ_W-1:0]        sqp5_reg [3];
    logic [SQ_W-1:0]        sq6_next;
    logic [SQ_W-1:0]        sq6_reg;
    logic [NORM_STAGES-1:0] valid_reg;

    function automatic logic [5:0] lead_zeros(input logic [WORD_W-1:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (x[i])
                n = 6'(WORD_W - 1 - i);
        end
        return n;
    endfunction

    // stage 1: contact status and component magnitudes
    always_comb
    begin
        side1_next.vel = vel;
        side1_next.ma  = mass_a;
        side1_next.mb  = mass_b;
        for (int i = 0; i < 3; i++)
        begin
            side1_next.neg[i] = rel_pos[i][WORD_W-1];
            side1_next.ar[i]  = rel_pos[i][WORD_W-1] ? (~rel_pos[i] + 32'd1) : rel_pos[i];
        end
        if (!separation[WORD_W-1] && (separation != '0))
            side1_next.status = ST_NONE;
        else if (rel_pos == '0)
            side1_next.status = ST_ZERO;
        else
            side1_next.status = ST_HIT;
    end

    // stage 2: largest magnitude
    always_comb
    begin
        mx01     = (side1_reg.ar[0] > side1_reg.ar[1]) ? side1_reg.ar[0] : side1_reg.ar[1];
        mx2_next = (mx01 > side1_reg.ar[2]) ? mx01 : side1_reg.ar[2];
    end

    // stage 3: shift that lifts the largest magnitude to at least 2^30
    always_comb
    begin
        lz       = lead_zeros(mx2_reg);
        sh3_next = (lz == 6'd0) ? 5'd0 : 5'(lz - 6'd1);
    end

    // stage 4: apply the shift
    always_comb
    begin
        side4_next = side3_reg;
        for (int i = 0; i < 3; i++)
            side4_next.ar[i] = side3_reg.ar[i] << sh3_reg;
    end

    // stages 5 and 6: squares, then their sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sqp5_next[i] = side4_reg.ar[i] * side4_reg.ar[i];
        sq6_next = sqp5_reg[0] + sqp5_reg[1] + sqp5_reg[2];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NORM_STAGES-2:0], in_valid};
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            mx2_reg   <= mx2_next;
            side3_reg <= side2_reg;
            sh3_reg   <= sh3_next;
            side4_reg <= side4_next;
            side5_reg <= side4_reg;
            sqp5_reg  <= sqp5_next;
            side6_reg <= side5_reg;
            sq6_reg   <= sq6_next;
        end
    end

    assign out_valid = valid_reg[NORM_STAGES-1];
    assign sq        = sq6_reg;
    assign side      = side6_reg;

endmodule

FILE: hw/rtl/ec3d_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module ec3d_isqrt
    import ec3d_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SQ_W-1:0]     radicand,
    output logic [ROOT_W-1:0]   root
);

    logic [SQ_W-1:0] x_reg  [SQRT_STAGES];
    logic [SQ_W-1:0] r_reg  [SQRT_STAGES];
    logic [SQ_W-1:0] x_next [SQRT_STAGES];
    logic [SQ_W-1:0] r_next [SQRT_STAGES];
    logic [SQ_W-1:0] x_in   [SQRT_STAGES];
    logic [SQ_W-1:0] r_in   [SQRT_STAGES];
    logic [SQ_W-1:0] bit_v  [SQRT_STAGES];
    logic [SQ_W-1:0] trial  [SQRT_STAGES];

    // each stage tries one bit of the root
    always_comb
    begin
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            x_in[k]  = (k == 0) ? radicand : x_reg[(k == 0) ? 0 : k - 1];
            r_in[k]  = (k == 0) ? '0 : r_reg[(k == 0) ? 0 : k - 1];
            bit_v[k] = 64'd1 << (SQ_W - 2 - 2 * k);
            trial[k] = r_in[k] + bit_v[k];
            if (x_in[k] >= trial[k])
            begin
                x_next[k] = x_in[k] - trial[k];
                r_next[k] = (r_in[k] >> 1) + bit_v[k];
            end
            else
            begin
                x_next[k] = x_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            r_reg <= r_next;
        end
    end

    assign root = r_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

FILE: hw/rtl/ec3d_div.sv
// pipelined restoring divider: floor(num * 2^32 / den) for num <= den
`timescale 1ns / 1ps
module ec3d_div
    import ec3d_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [QUO_W-1:0]  num,
    input  logic [QUO_W-1:0]  den,
    output logic [QUO_W-1:0]  quo,
    output logic              rem_nz
);

    logic [QUO_W:0]   rem_reg  [DIV_STAGES];
    logic [QUO_W:0]   rem_next [DIV_STAGES];
    logic [QUO_W-1:0] q_reg    [DIV_STAGES];
    logic [QUO_W-1:0] q_next   [DIV_STAGES];
    logic [QUO_W-1:0] d_reg    [DIV_STAGES];
    logic [QUO_W-1:0] d_next   [DIV_STAGES];
    logic [QUO_W:0]   r_in     [DIV_STAGES];
    logic             qbit     [DIV_STAGES];

    // one quotient bit per stage, most significant first
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                r_in[k]   = {1'b0, num};
                d_next[k] = den;
            end
            else
            begin
                r_in[k]   = {rem_reg[(k == 0) ? 0 : k - 1][QUO_W-1:0], 1'b0};
                d_next[k] = d_reg[(k == 0) ? 0 : k - 1];
            end
            qbit[k] = (r_in[k] >= {1'b0, d_next[k]});
            rem_next[k] = qbit[k] ? (r_in[k] - {1'b0, d_next[k]}) : r_in[k];
            if (k == 0)
                q_next[k] = {{(QUO_W-1){1'b0}}, qbit[k]};
            else
                q_next[k] = {q_reg[(k == 0) ? 0 : k - 1][QUO_W-2:0], qbit[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            d_reg   <= d_next;
        end
    end

    assign quo    = q_reg[DIV_STAGES-1];
    assign rem_nz = (rem_reg[DIV_STAGES-1] != '0);

endmodule

FILE: hw/rtl/ec3d_exch.sv
// back end: projections, momentum exchange, rebuild and saturation
`timescale 1ns / 1ps
module ec3d_exch
    import ec3d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  exch_side_t             side,
    input  logic [2:0][QUO_W-1:0]  q_dir,
    input  logic [QUO_W-1:0]       q_wgt,
    input  logic                   wgt_rem_nz,
    output logic                   out_valid,
    output vel_pair_t              out_vel,
    output status_t                out_status
);

    typedef struct packed {
        status_t                status;
        vel_pair_t              vel;
        logic [2:0][WORD_W-1:0] u;
        logic [QUO_W-1:0]       wa;
        logic [QUO_W-1:0]       wb;
    } carry_t;

    carry_t                  carry_reg  [EXCH_STAGES];
    carry_t                  carry_next [EXCH_STAGES];
    logic [EXCH_STAGES-1:0]  valid_reg;

    logic signed [63:0] prod_a_next [3];
    logic signed [63:0] prod_b_next [3];
    logic signed [63:0] prod_a_reg  [3];
    logic signed [63:0] prod_b_reg  [3];
    logic signed [63:0] dot_a_next, dot_b_next, dot_a_reg, dot_b_reg;
    logic signed [63:0] rs64_a, rs64_b;
    logic signed [33:0] pa_next, pb_next, pa_reg, pb_reg;
    logic signed [34:0] diff_a_next, diff_b_next, diff_a_reg, diff_b_reg;
    logic        [64:0] wpl_a_next, wpl_b_next, wpl_a_reg, wpl_b_reg;
    logic signed [36:0] wph_a_next, wph_b_next, wph_a_reg, wph_b_reg;
    logic signed [68:0] wfull_a_next, wfull_b_next, wfull_a_reg, wfull_b_reg;
    logic signed [68:0] rs69_a, rs69_b;
    logic signed [37:0] da_next, db_next, da_reg, db_reg;
    logic signed [64:0] cpl_a_next [3];
    logic signed [64:0] cpl_b_next [3];
    logic signed [64:0] cpl_a_reg  [3];
    logic signed [64:0] cpl_b_reg  [3];
    logic signed [37:0] cph_a_next [3];
    logic signed [37:0] cph_b_next [3];
    logic signed [37:0] cph_a_reg  [3];
    logic signed [37:0] cph_b_reg  [3];
    logic signed [69:0] cfull_a_next [3];
    logic signed [69:0] cfull_b_next [3];
    logic signed [69:0] cfull_a_reg  [3];
    logic signed [69:0] cfull_b_reg  [3];
    logic signed [69:0] rs70_a [3];
    logic signed [69:0] rs70_b [3];
    logic signed [39:0] ca_next [3];
    logic signed [39:0] cb_next [3];
    logic signed [39:0] ca_reg  [3];
    logic signed [39:0] cb_reg  [3];
    logic signed [40:0] sum_a [3];
    logic signed [40:0] sum_b [3];
    logic [WORD_W-1:0]  umag [3];

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [40:0] v);
        if (v[40:31] == {10{v[40]}})
            return v[31:0];
        else if (v[40])
            return 32'h8000_0000;
        else
            return 32'h7FFF_FFFF;
    endfunction

    always_comb
    begin
        // stage 1: signed unit direction and mass weights
        carry_next[0].status = side.status;
        carry_next[0].vel    = side.vel;
        for (int i = 0; i < 3; i++)
        begin
            umag[i] = {1'b0, q_dir[i][QUO_W-1:2]};
            carry_next[0].u[i] = side.neg[i] ? (~umag[i] + 32'd1) : umag[i];
        end
        if (side.szero)
        begin
            carry_next[0].wa = 33'h0_8000_0000;
            carry_next[0].wb = 33'h0_8000_0000;
        end
        else
        begin
            carry_next[0].wa = q_wgt;
            carry_next[0].wb = 33'h1_0000_0000 - q_wgt - {32'd0, wgt_rem_nz};
        end

        // sideband travels unchanged through the later stages
        for (int k = 1; k < EXCH_STAGES; k++)
            carry_next[k] = carry_reg[k-1];

        // stage 2: velocity times direction
        for (int i = 0; i < 3; i++)
        begin
            prod_a_next[i] = $signed(carry_reg[0].vel.va[i]) * $signed(carry_reg[0].u[i]);
            prod_b_next[i] = $signed(carry_reg[0].vel.vb[i]) * $signed(carry_reg[0].u[i]);
        end

        // stage 3: dot products
        dot_a_next = prod_a_reg[0] + prod_a_reg[1] + prod_a_reg[2];
        dot_b_next = prod_b_reg[0] + prod_b_reg[1] + prod_b_reg[2];

        // stage 4: along-line speeds, rounded half away from zero
        rs64_a  = dot_a_reg + (dot_a_reg[63] ? 64'sh1FFF_FFFF : 64'sh2000_0000);
        rs64_b  = dot_b_reg + (dot_b_reg[63] ? 64'sh1FFF_FFFF : 64'sh2000_0000);
        pa_next = $signed(rs64_a[63:30]);
        pb_next = $signed(rs64_b[63:30]);

        // stage 5: speed differences
        diff_a_next = $signed({pb_reg[33], pb_reg}) - $signed({pa_reg[33], pa_reg});
        diff_b_next = $signed({pa_reg[33], pa_reg}) - $signed({pb_reg[33], pb_reg});

        // stage 6: partial products of difference and weight
        wpl_a_next = diff_a_reg[31:0] * carry_reg[4].wb;
        wpl_b_next = diff_b_reg[31:0] * carry_reg[4].wa;
        wph_a_next = $signed(diff_a_reg[34:32]) * $signed({1'b0, carry_reg[4].wb});
        wph_b_next = $signed(diff_b_reg[34:32]) * $signed({1'b0, carry_reg[4].wa});

        // stage 7: combine partial products
        wfull_a_next = $signed({wph_a_reg, 32'd0}) + $signed({4'd0, wpl_a_reg});
        wfull_b_next = $signed({wph_b_reg, 32'd0}) + $signed({4'd0, wpl_b_reg});

        // stage 8: speed changes
        rs69_a  = wfull_a_reg + (wfull_a_reg[68] ? 69'sh3FFF_FFFF : 69'sh4000_0000);
        rs69_b  = wfull_b_reg + (wfull_b_reg[68] ? 69'sh3FFF_FFFF : 69'sh4000_0000);
        da_next = $signed(rs69_a[68:31]);
        db_next = $signed(rs69_b[68:31]);

        for (int i = 0; i < 3; i++)
        begin
            // stage 9: partial products of change and direction
            cpl_a_next[i] = $signed({1'b0, da_reg[31:0]}) * $signed(carry_reg[7].u[i]);
            cpl_b_next[i] = $signed({1'b0, db_reg[31:0]}) * $signed(carry_reg[7].u[i]);
            cph_a_next[i] = $signed(da_reg[37:32]) * $signed(carry_reg[7].u[i]);
            cph_b_next[i] = $signed(db_reg[37:32]) * $signed(carry_reg[7].u[i]);

            // stage 10: combine
            cfull_a_next[i] = $signed({cph_a_reg[i], 32'd0})
                            + $signed({{5{cpl_a_reg[i][64]}}, cpl_a_reg[i]});
            cfull_b_next[i] = $signed({cph_b_reg[i], 32'd0})
                            + $signed({{5{cpl_b_reg[i][64]}}, cpl_b_reg[i]});

            // stage 11: per-axis correction
            rs70_a[i]  = cfull_a_reg[i]
                       + (cfull_a_reg[i][69] ? 70'sh1FFF_FFFF : 70'sh2000_0000);
            rs70_b[i]  = cfull_b_reg[i]
                       + (cfull_b_reg[i][69] ? 70'sh1FFF_FFFF : 70'sh2000_0000);
            ca_next[i] = $signed(rs70_a[i][69:30]);
            cb_next[i] = $signed(rs70_b[i][69:30]);

            // stage 12: rebuild and saturate on a contact
            sum_a[i] = $signed({{9{carry_reg[10].vel.va[i][31]}}, carry_reg[10].vel.va[i]})
                     + $signed({ca_reg[i][39], ca_reg[i]});
            sum_b[i] = $signed({{9{carry_reg[10].vel.vb[i][31]}}, carry_reg[10].vel.vb[i]})
                     + $signed({cb_reg[i][39], cb_reg[i]});
            if (carry_reg[10].status == ST_HIT)
            begin
                carry_next[EXCH_STAGES-1].vel.va[i] = sat_word(sum_a[i]);
                carry_next[EXCH_STAGES-1].vel.vb[i] = sat_word(sum_b[i]);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[EXCH_STAGES-2:0], in_valid};
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg   <= carry_next;
            prod_a_reg  <= prod_a_next;
            prod_b_reg  <= prod_b_next;
            dot_a_reg   <= dot_a_next;
            dot_b_reg   <= dot_b_next;
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            diff_a_reg  <= diff_a_next;
            diff_b_reg  <= diff_b_next;
            wpl_a_reg   <= wpl_a_next;
            wpl_b_reg   <= wpl_b_next;
            wph_a_reg   <= wph_a_next;
            wph_b_reg   <= wph_b_next;
            wfull_a_reg <= wfull_a_next;
            wfull_b_reg <= wfull_b_next;
            da_reg      <= da_next;
            db_reg      <= db_next;
            cpl_a_reg   <= cpl_a_next;
            cpl_b_reg   <= cpl_b_next;
            cph_a_reg   <= cph_a_next;
            cph_b_reg   <= cph_b_next;
            cfull_a_reg <= cfull_a_next;
            cfull_b_reg <= cfull_b_next;
            ca_reg      <= ca_next;
            cb_reg      <= cb_next;
        end
    end

    assign out_valid  = valid_reg[EXCH_STAGES-1];
    assign out_vel    = carry_reg[EXCH_STAGES-1].vel;
    assign out_status = carry_reg[EXCH_STAGES-1].status;

endmodule

FILE: hw/rtl/elastic_collision_3d.sv
// 3d elastic sphere collision, signed q16.16, one request per cycle while req_stall is low
// pipeline of 6 front end, 32 square root, 33 divider and 12 exchange stages
// accepts one request every cycle unless stalled; the square root and dividers are fully pipelined
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// rst_n clears all valid bits asynchronously; no clearing pass is needed
`timescale 1ns / 1ps
`include "assert_macros.svh"
module elastic_collision_3d
    import ec3d_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic signed [WORD_W-1:0]  separation,
    input  logic [MASS_W-1:0]         mass_a,
    input  logic [MASS_W-1:0]         mass_b,
    input  logic signed [WORD_W-1:0]  vel_a_x,
    input  logic signed [WORD_W-1:0]  vel_a_y,
    input  logic signed [WORD_W-1:0]  vel_a_z,
    input  logic signed [WORD_W-1:0]  vel_b_x,
    input  logic signed [WORD_W-1:0]  vel_b_y,
    input  logic signed [WORD_W-1:0]  vel_b_z,
    input  logic signed [WORD_W-1:0]  rel_pos_x,
    input  logic signed [WORD_W-1:0]  rel_pos_y,
    input  logic signed [WORD_W-1:0]  rel_pos_z,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic signed [WORD_W-1:0]  new_vel_a_x,
    output logic signed [WORD_W-1:0]  new_vel_a_y,
    output logic signed [WORD_W-1:0]  new_vel_a_z,
    output logic signed [WORD_W-1:0]  new_vel_b_x,
    output logic signed [WORD_W-1:0]  new_vel_b_y,
    output logic signed [WORD_W-1:0]  new_vel_b_z,
    output logic [1:0]                status
);

    logic                    en;
    vel_pair_t               in_vel;
    logic [2:0][WORD_W-1:0]  in_rel;
    logic                    n_valid;
    logic [SQ_W-1:0]         n_sq;
    norm_side_t              n_side;
    logic [ROOT_W-1:0]       root;
    logic [SQRT_STAGES-1:0]  sq_valid_reg;
    norm_side_t              sq_side_reg [SQRT_STAGES];
    norm_side_t              sq_out;
    exch_side_t              x_side;
    logic [WORD_W-1:0]       mass_sum;
    logic [DIV_STAGES-1:0]   dv_valid_reg;
    exch_side_t              dv_side_reg [DIV_STAGES];
    logic [2:0][QUO_W-1:0]   q_dir;
    logic [QUO_W-1:0]        q_wgt;
    logic                    wgt_rem_nz;
    vel_pair_t               out_vel;
    status_t                 out_status;

    // the whole pipeline moves unless a finished result is held up
    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    always_comb
    begin
        in_vel.va = {vel_a_z, vel_a_y, vel_a_x};
        in_vel.vb = {vel_b_z, vel_b_y, vel_b_x};
        in_rel    = {rel_pos_z, rel_pos_y, rel_pos_x};
    end

    // front end
    ec3d_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (req_valid),
        .separation (separation),
        .mass_a     (mass_a),
        .mass_b     (mass_b),
        .vel        (in_vel),
        .rel_pos    (in_rel),
        .out_valid  (n_valid),
        .sq         (n_sq),
        .side       (n_side)
    );

    // length of the scaled relative position
    ec3d_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (n_sq),
        .root     (root)
    );

    // sideband alongside the square root and the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= '0;
            dv_valid_reg <= '0;
        end
        else if (en)
        begin
            sq_valid_reg <= {sq_valid_reg[SQRT_STAGES-2:0], n_valid};
            dv_valid_reg <= {dv_valid_reg[DIV_STAGES-2:0], sq_valid_reg[SQRT_STAGES-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= n_side;
            for (int k = 1; k < SQRT_STAGES; k++)
                sq_side_reg[k] <= sq_side_reg[k-1];
            dv_side_reg[0] <= x_side;
            for (int k = 1; k < DIV_STAGES; k++)
                dv_side_reg[k] <= dv_side_reg[k-1];
        end
    end

    // sideband handed on to the exchange stages
    always_comb
    begin
        sq_out        = sq_side_reg[SQRT_STAGES-1];
        mass_sum      = {1'b0, sq_out.ma} + {1'b0, sq_out.mb};
        x_side.status = sq_out.status;
        x_side.neg    = sq_out.neg;
        x_side.vel    = sq_out.vel;
        x_side.szero  = (mass_sum == '0);
    end

    // unit direction, one divider per axis
    for (genvar i = 0; i < 3; i++)
    begin : g_dir
        ec3d_div u_div (
            .clk    (clk),
            .en     (en),
            .num    ({1'b0, sq_out.ar[i]}),
            .den    ({1'b0, root}),
            .quo    (q_dir[i]),
            .rem_nz ()
        );
    end

    // mass weight of the first particle
    ec3d_div u_wgt (
        .clk    (clk),
        .en     (en),
        .num    ({2'b0, sq_out.ma}),
        .den    ({1'b0, mass_sum}),
        .quo    (q_wgt),
        .rem_nz (wgt_rem_nz)
    );

    // projection, exchange and rebuild
    ec3d_exch u_exch (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (dv_valid_reg[DIV_STAGES-1]),
        .side       (dv_side_reg[DIV_STAGES-1]),
        .q_dir      (q_dir),
        .q_wgt      (q_wgt),
        .wgt_rem_nz (wgt_rem_nz),
        .out_valid  (res_valid),
        .out_vel    (out_vel),
        .out_status (out_status)
    );

    assign new_vel_a_x = $signed(out_vel.va[0]);
    assign new_vel_a_y = $signed(out_vel.va[1]);
    assign new_vel_a_z = $signed(out_vel.va[2]);
    assign new_vel_b_x = $signed(out_vel.vb[0]);
    assign new_vel_b_y = $signed(out_vel.vb[1]);
    assign new_vel_b_z = $signed(out_vel.vb[2]);
    assign status      = out_status;

    // normalised squares always reach 2^60 on a contact
    `CHK_IMPLY(a_sq_floor, n_valid && (n_side.status == ST_HIT), n_sq >= 64'h1000_0000_0000_0000)
    // so the length is at least 2^30
    `CHK_IMPLY(a_len_floor, sq_valid_reg[SQRT_STAGES-1] && (sq_out.status == ST_HIT), root >= 32'h4000_0000)
    // no direction component exceeds one
    `CHK_IMPLY(a_dir_bound, dv_valid_reg[DIV_STAGES-1] && (dv_side_reg[DIV_STAGES-1].status == ST_HIT), (q_dir[0] <= 33'h1_0000_0000) && (q_dir[1] <= 33'h1_0000_0000) && (q_dir[2] <= 33'h1_0000_0000))

endmodule
